// ===== hw/rtl/blft_pkg.sv =====
// shared types and constants for the beam local force transform
`timescale 1ns / 1ps

package blft_pkg;

    // input beat: two joint positions, signed q16.16
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } t_beam_in;

    // output beat: force in the local frame, signed q16.16
    typedef struct packed {
        logic signed [31:0] local_axial;
        logic signed [31:0] local_normal;
        logic signed [31:0] local_lateral;
        logic               saturated;
    } t_force_out;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_FORCE_X = 2'd0;
    localparam logic [1:0] CFG_FORCE_Y = 2'd1;
    localparam logic [1:0] CFG_FORCE_Z = 2'd2;

    localparam logic signed [31:0] FORCE_X_RESET = 32'sd65536;

    // 1.0 in q2.30 and 1.0 squared in q4.60
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [61:0] ONE_Q60  = 62'h1000_0000_0000_0000;
    // half lsb for the final q2.30 -> q16.16 scaling
    localparam logic [65:0] ROUND_HALF = 66'h0_0000_0000_2000_0000;

    localparam logic [35:0] NEG_LIMIT = 36'h0_8000_0000;
    localparam logic [35:0] POS_LIMIT = 36'h0_7FFF_FFFF;

endpackage

// ===== hw/rtl/blft_sqrt.sv =====
// integer square root as a row of bit cells, one result bit per cell
`timescale 1ns / 1ps

module blft_sqrt #(
    parameter int IW  = 64,
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IW-1:0]     i_rad,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_valid,
    output logic [IW/2-1:0]   o_root,
    output logic [SBW-1:0]    o_sb
);
    localparam int RB = IW / 2;
    localparam int TW = IW + 1;

    logic          r_v    [RB];
    logic [IW-1:0] r_rem  [RB];
    logic [RB-1:0] r_root [RB];
    logic [SBW-1:0] r_sb  [RB];

    for (genvar k = 0; k < RB; k++) begin : g_cell
        localparam int J = RB - 1 - k;
        logic           v_in;
        logic [IW-1:0]  rem_in;
        logic [RB-1:0]  root_in;
        logic [SBW-1:0] sb_in;
        logic [TW-1:0]  trial;
        logic           fit;

        if (k == 0) begin : g_head
            assign v_in    = i_valid;
            assign rem_in  = i_rad;
            assign root_in = '0;
            assign sb_in   = i_sb;
        end else begin : g_link
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign sb_in   = r_sb[k-1];
        end

        // (2*root + 2^j) * 2^j, the growth of root^2 when bit j is set
        assign trial = (TW'(root_in) << (J + 1)) + (TW'(1) << (2 * J));
        assign fit   = TW'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= fit ? IW'(TW'(rem_in) - trial) : rem_in;
                r_root[k] <= fit ? (root_in | (RB'(1) << J)) : root_in;
                r_sb[k]   <= sb_in;
            end
        end
    end

    assign o_valid = r_v[RB-1];
    assign o_root  = r_root[RB-1];
    assign o_sb    = r_sb[RB-1];

endmodule

// ===== hw/rtl/blft_div.sv =====
// saturating restoring divider as a row of bit cells, lanes share one divisor
`timescale 1ns / 1ps

module blft_div #(
    parameter int NW    = 62,
    parameter int DW    = 32,
    parameter int QB    = 31,
    parameter int LANES = 3,
    parameter int SBW   = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NW-1:0]    i_num,
    input  logic [DW-1:0]               i_den,
    input  logic [SBW-1:0]              i_sb,
    output logic                        o_valid,
    output logic [LANES-1:0][QB-1:0]    o_quo,
    output logic [SBW-1:0]              o_sb
);
    localparam int NS = QB + 1;
    localparam int QW = QB + 1;
    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic                     r_v   [NS];
    logic [LANES-1:0][NW-1:0] r_rem [NS];
    logic [LANES-1:0][QW-1:0] r_quo [NS];
    logic [DW-1:0]            r_den [NS];
    logic [SBW-1:0]           r_sb  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_cell
        localparam int J = QB - k;
        logic                     v_in;
        logic [LANES-1:0][NW-1:0] rem_in;
        logic [LANES-1:0][QW-1:0] quo_in;
        logic [DW-1:0]            den_in;
        logic [SBW-1:0]           sb_in;
        logic [CW-1:0]            step;
        logic [LANES-1:0][NW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_quo;

        if (k == 0) begin : g_head
            assign v_in   = i_valid;
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
            assign sb_in  = i_sb;
        end else begin : g_link
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
            assign sb_in  = r_sb[k-1];
        end

        // top cell only flags an oversized quotient
        assign step = CW'(den_in) << J;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (CW'(rem_in[l]) >= step) begin
                    n_rem[l] = NW'(CW'(rem_in[l]) - step);
                    n_quo[l] = quo_in[l] | (QW'(1) << J);
                end else begin
                    n_rem[l] = rem_in[l];
                    n_quo[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_den[k] <= den_in;
                r_sb[k]  <= sb_in;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_quo[NS-1][l][QB] ? '1 : r_quo[NS-1][l][QB-1:0];
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_sb    = r_sb[NS-1];

endmodule

// ===== hw/rtl/beam_local_force_transform.sv =====
// top level: rotates the configured force into the local frame of each beam
`timescale 1ns / 1ps

// usage
//   input channel: i_valid / o_stall with i_beam, one beam per beat (two end points)
//   output channel: o_valid / i_stall with o_force, one result beat per beam, in order
//   config channel: i_cfg_valid / o_cfg_ready, index 0..2 selects force x, y, z;
//   o_cfg_ready is always high, other indexes are dropped; write only while idle
// pipeline
//   most of the depth lies in the four cell rows: length square root
//   (32 cells), direction divide (32 cells), den square root (31 cells)
//   and matrix entry divide (32 cells)
// throughput
//   one beam per cycle while o_stall is low; cells hand data on at each advance
// reset
//   synchronous, active low; clears all valid bits and loads force = (1.0, 0, 0)
// stall
//   the whole pipe moves on one advance signal; when the receiver stalls a
//   waiting result, the next result lands in a skid register and the pipe only
//   freezes (o_stall high) once the skid register is full

module beam_local_force_transform (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  blft_pkg::t_beam_in     i_beam,
    output logic                   o_valid,
    input  logic                   i_stall,
    output blft_pkg::t_force_out   o_force,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import blft_pkg::*;

    // sideband bundles carried through the cell rows
    typedef struct packed {
        logic [2:0][30:0] s;
        logic [2:0]       n;
        logic             zero;
    } t_sb_len;

    typedef struct packed {
        logic [2:0] n;
        logic       zero;
    } t_sb_dir;

    typedef struct packed {
        logic [2:0][30:0] cm;
        logic [1:0][61:0] p;
        logic [2:0]       n;
        logic             vert;
    } t_sb_den;

    typedef struct packed {
        logic [2:0][30:0] cm;
        logic [2:0]       n;
        logic             vert;
        logic [30:0]      den;
    } t_sb_ent;

    function automatic logic signed [31:0] f_signed(input logic [30:0] mag, input logic neg);
        logic signed [31:0] v;
        v = signed'({1'b0, mag});
        return neg ? -v : v;
    endfunction

    // force registers
    logic signed [31:0] r_fx, r_fy, r_fz;
    logic signed [31:0] w_f [3];

    // pipe control
    logic w_adv;
    logic r_out_valid, r_skid_valid;
    t_force_out r_out, r_skid, w_res;
    logic w_arrive;

    // front stages
    logic             r1_v;
    t_beam_in         r1_beam;
    logic [2:0][32:0] w_d;
    logic [2:0][31:0] w_a;
    logic             r2_v;
    logic [2:0][31:0] r2_a;
    logic [2:0]       r2_n;
    logic [31:0]      w_mx;
    logic [4:0]       w_lz;
    logic             r3_v;
    logic [2:0][31:0] r3_a;
    logic [2:0]       r3_n;
    logic             r3_right, r3_zero;
    logic [4:0]       r3_lz;
    logic             r4_v;
    logic [2:0][30:0] r4_s;
    logic [2:0]       r4_n;
    logic             r4_zero;
    logic             r5_v;
    logic [2:0][61:0] r5_sq;
    logic [2:0][30:0] r5_s;
    logic [2:0]       r5_n;
    logic             r5_zero;
    logic             r6_v;
    logic [63:0]      r6_sum;
    t_sb_len          r6_sb;

    // length and direction
    logic                        w_len_v;
    logic [31:0]                 w_len;
    logic [$bits(t_sb_len)-1:0]  w_len_sb_raw;
    t_sb_len                     w_len_sb;
    logic                        r7_v;
    logic [2:0][61:0]            r7_num;
    logic [31:0]                 r7_den;
    t_sb_dir                     r7_sb;
    logic                        w_dir_v;
    logic [2:0][30:0]            w_dir_q;
    logic [$bits(t_sb_dir)-1:0]  w_dir_sb_raw;
    t_sb_dir                     w_dir_sb;
    logic                        r8_v;
    logic [2:0][30:0]            r8_cm;
    logic [2:0]                  r8_n;
    logic                        r9_v;
    logic [61:0]                 r9_sq;
    t_sb_den                     r9_sb;
    logic                        r10_v;
    logic [61:0]                 r10_rad;
    t_sb_den                     r10_sb;

    // den and matrix entries
    logic                        w_den_v;
    logic [30:0]                 w_den;
    logic [$bits(t_sb_den)-1:0]  w_den_sb_raw;
    t_sb_den                     w_den_sb;
    logic [29:0]                 w_half;
    logic                        r11_v;
    logic [3:0][61:0]            r11_num;
    t_sb_ent                     r11_sb;
    logic                        w_ent_v;
    logic [3:0][30:0]            w_ent_q;
    logic [$bits(t_sb_ent)-1:0]  w_ent_sb_raw;
    t_sb_ent                     w_ent_sb;
    logic signed [31:0]          w_c [3];
    logic signed [31:0]          w_m  [3][3];
    logic                        r12_v;
    logic signed [31:0]          r12_m [3][3];
    logic                        r13_v;
    logic signed [63:0]          r13_p [3][3];
    logic                        r14_v;
    logic signed [65:0]          r14_acc [3];

    // output rounding
    logic [65:0]        w_mag  [3];
    logic [65:0]        w_rsum [3];
    logic [35:0]        w_q    [3];
    logic signed [31:0] w_row  [3];
    logic [2:0]         w_sat;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= FORCE_X_RESET;
            r_fy <= '0;
            r_fz <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FORCE_X: r_fx <= signed'(i_cfg_data);
                CFG_FORCE_Y: r_fy <= signed'(i_cfg_data);
                CFG_FORCE_Z: r_fz <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign w_f[0] = r_fx;
    assign w_f[1] = r_fy;
    assign w_f[2] = r_fz;

    // ------------------------------------------------------- pipe advance
    // the pipe only holds when the skid register is occupied
    assign w_adv   = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // ------------------------------------------------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
            r13_v <= 1'b0;
            r14_v <= 1'b0;
        end else if (w_adv) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= w_len_v;
            r8_v  <= w_dir_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= w_den_v;
            r12_v <= w_ent_v;
            r13_v <= r12_v;
            r14_v <= r13_v;
        end
    end

    // ------------------------------------------------------- beam difference
    // 33 bit differences, split into sign and magnitude
    assign w_d[0] = {r1_beam.end_x[31], r1_beam.end_x} - {r1_beam.start_x[31], r1_beam.start_x};
    assign w_d[1] = {r1_beam.end_y[31], r1_beam.end_y} - {r1_beam.start_y[31], r1_beam.start_y};
    assign w_d[2] = {r1_beam.end_z[31], r1_beam.end_z} - {r1_beam.start_z[31], r1_beam.start_z};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = w_d[i][32] ? 32'(~w_d[i] + 33'd1) : w_d[i][31:0];
        end
    end

    // largest magnitude and its leading zero count
    always_comb begin
        w_mx = r2_a[0];
        if (r2_a[1] > w_mx) begin
            w_mx = r2_a[1];
        end
        if (r2_a[2] > w_mx) begin
            w_mx = r2_a[2];
        end
    end

    always_comb begin
        w_lz = '0;
        for (int b = 0; b < 31; b++) begin
            if (w_mx[b]) begin
                w_lz = 5'(30 - b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_beam  <= i_beam;

            r2_a     <= w_a;
            r2_n     <= {w_d[2][32], w_d[1][32], w_d[0][32]};

            r3_a     <= r2_a;
            r3_n     <= r2_n;
            r3_right <= w_mx[31];
            r3_zero  <= (w_mx == '0);
            r3_lz    <= w_lz;

            // shift all three together so the largest lands in [2^30, 2^31)
            for (int i = 0; i < 3; i++) begin
                r4_s[i] <= r3_right ? r3_a[i][31:1] : 31'(r3_a[i] << r3_lz);
            end
            r4_n     <= r3_n;
            r4_zero  <= r3_zero;

            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= 62'(r4_s[i]) * 62'(r4_s[i]);
            end
            r5_s     <= r4_s;
            r5_n     <= r4_n;
            r5_zero  <= r4_zero;

            r6_sum   <= 64'(r5_sq[0]) + 64'(r5_sq[1]) + 64'(r5_sq[2]);
            r6_sb.s  <= r5_s;
            r6_sb.n  <= r5_n;
            r6_sb.zero <= r5_zero;
        end
    end

    // ------------------------------------------------------- beam length
    blft_sqrt #(
        .IW  (64),
        .SBW ($bits(t_sb_len))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r6_v),
        .i_rad   (r6_sum),
        .i_sb    (r6_sb),
        .o_valid (w_len_v),
        .o_root  (w_len),
        .o_sb    (w_len_sb_raw)
    );

    assign w_len_sb = t_sb_len'(w_len_sb_raw);

    // rounded numerators for the direction cosines
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r7_num[i] <= 62'({w_len_sb.s[i], 30'd0}) + 62'(w_len[31:1]);
            end
            r7_den     <= w_len;
            r7_sb.n    <= w_len_sb.n;
            r7_sb.zero <= w_len_sb.zero;
        end
    end

    blft_div #(
        .NW    (62),
        .DW    (32),
        .QB    (31),
        .LANES (3),
        .SBW   ($bits(t_sb_dir))
    ) u_dir_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r7_v),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_sb    (r7_sb),
        .o_valid (w_dir_v),
        .o_quo   (w_dir_q),
        .o_sb    (w_dir_sb_raw)
    );

    assign w_dir_sb = t_sb_dir'(w_dir_sb_raw);

    // ------------------------------------------------------- den = sqrt(1 - cy^2)
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // zero length beam leaves the direction at zero
            for (int i = 0; i < 3; i++) begin
                if (w_dir_sb.zero) begin
                    r8_cm[i] <= '0;
                end else if (w_dir_q[i] > ONE_Q30) begin
                    r8_cm[i] <= ONE_Q30;
                end else begin
                    r8_cm[i] <= w_dir_q[i];
                end
            end
            r8_n <= w_dir_sb.n;

            r9_sq      <= 62'(r8_cm[1]) * 62'(r8_cm[1]);
            r9_sb.p[0] <= 62'(r8_cm[0]) * 62'(r8_cm[1]);
            r9_sb.p[1] <= 62'(r8_cm[1]) * 62'(r8_cm[2]);
            r9_sb.cm   <= r8_cm;
            r9_sb.n    <= r8_n;
            r9_sb.vert <= (r8_cm[1] == ONE_Q30);

            r10_rad <= ONE_Q60 - r9_sq;
            r10_sb  <= r9_sb;
        end
    end

    blft_sqrt #(
        .IW  (62),
        .SBW ($bits(t_sb_den))
    ) u_den_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r10_v),
        .i_rad   (r10_rad),
        .i_sb    (r10_sb),
        .o_valid (w_den_v),
        .o_root  (w_den),
        .o_sb    (w_den_sb_raw)
    );

    assign w_den_sb = t_sb_den'(w_den_sb_raw);
    assign w_half   = w_den[30:1];

    // rounded numerators of the four divided matrix entries
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r11_num[0]  <= w_den_sb.p[0] + 62'(w_half);
            r11_num[1]  <= w_den_sb.p[1] + 62'(w_half);
            r11_num[2]  <= 62'({w_den_sb.cm[2], 30'd0}) + 62'(w_half);
            r11_num[3]  <= 62'({w_den_sb.cm[0], 30'd0}) + 62'(w_half);
            r11_sb.cm   <= w_den_sb.cm;
            r11_sb.n    <= w_den_sb.n;
            r11_sb.vert <= w_den_sb.vert;
            r11_sb.den  <= w_den;
        end
    end

    blft_div #(
        .NW    (62),
        .DW    (31),
        .QB    (31),
        .LANES (4),
        .SBW   ($bits(t_sb_ent))
    ) u_ent_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r11_v),
        .i_num   (r11_num),
        .i_den   (r11_sb.den),
        .i_sb    (r11_sb),
        .o_valid (w_ent_v),
        .o_quo   (w_ent_q),
        .o_sb    (w_ent_sb_raw)
    );

    assign w_ent_sb = t_sb_ent'(w_ent_sb_raw);

    // ------------------------------------------------------- rotation matrix
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c[i] = f_signed(w_ent_sb.cm[i], w_ent_sb.n[i]);
        end

        if (w_ent_sb.vert) begin
            // vertical beam: fixed permutation rows
            w_m[0][0] = '0;      w_m[0][1] = w_c[1]; w_m[0][2] = '0;
            w_m[1][0] = -w_c[1]; w_m[1][1] = '0;     w_m[1][2] = '0;
            w_m[2][0] = '0;      w_m[2][1] = '0;     w_m[2][2] = signed'({1'b0, ONE_Q30});
        end else begin
            w_m[0][0] = w_c[0];
            w_m[0][1] = w_c[1];
            w_m[0][2] = w_c[2];
            w_m[1][0] = f_signed(w_ent_q[0], (w_ent_sb.n[0] == w_ent_sb.n[1])
                                 && (w_ent_sb.cm[0] != '0) && (w_ent_sb.cm[1] != '0));
            w_m[1][1] = signed'({1'b0, w_ent_sb.den});
            w_m[1][2] = f_signed(w_ent_q[1], (w_ent_sb.n[1] == w_ent_sb.n[2])
                                 && (w_ent_sb.cm[1] != '0) && (w_ent_sb.cm[2] != '0));
            w_m[2][0] = f_signed(w_ent_q[2], !w_ent_sb.n[2] && (w_ent_sb.cm[2] != '0));
            w_m[2][1] = '0;
            w_m[2][2] = f_signed(w_ent_q[3], w_ent_sb.n[0]);
        end
    end

    // matrix times force: products, then row sums
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r12_m <= w_m;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r13_p[r][c] <= r12_m[r][c] * w_f[c];
                end
                r14_acc[r] <= 66'(r13_p[r][0]) + 66'(r13_p[r][1]) + 66'(r13_p[r][2]);
            end
        end
    end

    // q2.30 x q16.16 back to q16.16, half away from zero, then clamp
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_mag[r]  = r14_acc[r][65] ? 66'(-r14_acc[r]) : 66'(r14_acc[r]);
            w_rsum[r] = w_mag[r] + ROUND_HALF;
            w_q[r]    = w_rsum[r][65:30];
            w_sat[r]  = 1'b0;
            if (r14_acc[r][65]) begin
                if (w_q[r] > NEG_LIMIT) begin
                    w_row[r] = signed'(NEG_LIMIT[31:0]);
                    w_sat[r] = 1'b1;
                end else begin
                    w_row[r] = signed'(32'(~w_q[r] + 36'd1));
                end
            end else begin
                if (w_q[r] > POS_LIMIT) begin
                    w_row[r] = signed'(POS_LIMIT[31:0]);
                    w_sat[r] = 1'b1;
                end else begin
                    w_row[r] = signed'(w_q[r][31:0]);
                end
            end
        end
    end

    assign w_res.local_axial   = w_row[0];
    assign w_res.local_normal  = w_row[1];
    assign w_res.local_lateral = w_row[2];
    assign w_res.saturated     = |w_sat;

    // ------------------------------------------------------- output and skid
    assign w_arrive = w_adv && r14_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_arrive;
            end
        end else if (w_arrive) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_arrive) begin
            r_skid <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_force = r_out;

endmodule

// ===== hw/rtl/blft_check.sv =====
// port level checks for the beam local force transform, bound to the top level
`timescale 1ns / 1ps

module blft_check (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input blft_pkg::t_force_out  o_force
);
    import blft_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_force))
        else $error("stalled result beat changed");

    // reset empties the output side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

    // input side only stalls while a result is waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // input stall only starts after a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall without output stall");

endmodule

bind beam_local_force_transform blft_check u_blft_check (.*);

// ===== tb/sv/tb_beam_local_force_transform.sv =====
// testbench for the beam local force transform: directed table, random beams, scoreboard
`timescale 1ns / 1ps

module tb_beam_local_force_transform;
    import blft_pkg::*;

    // index with no register behind it, written to check that it is dropped
    localparam logic [1:0] CFG_NONE = 2'd3;
    // pipe depth, used to size the drain wait and the long receiver hold
    localparam int PIPE_DEPTH = 141;
    localparam int DRAIN_WAIT = PIPE_DEPTH + 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEAMS = 1300;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_stall;
    t_beam_in     i_beam = '0;
    logic         o_valid;
    logic         i_stall = 1'b0;
    t_force_out   o_force;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    beam_local_force_transform dut (.*);

    always #2 i_clk = ~i_clk;

    // force vector as the block should hold it
    logic signed [67:0] force_q [3];

    t_force_out   expected_forces [$];
    int           mismatches = 0;
    int           beams_sent = 0;
    int           forces_seen = 0;
    int           sat_seen = 0;
    int           vertical_sent = 0;
    longint       cycles = 0;
    bit           long_hold_done = 1'b0;
    bit           stimulus_done = 1'b0;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic logic [63:0] isqrt_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] div_nearest(logic [63:0] n, logic [63:0] d);
        return (n + d / 2) / d;
    endfunction

    // signed matrix entry, magnitude rounded and clamped to 2^31 - 1
    function automatic logic signed [67:0] entry_of(logic [63:0] n, logic [63:0] d, bit neg);
        logic [63:0] q;
        q = div_nearest(n, d);
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return neg ? -$signed({4'b0, q}) : $signed({4'b0, q});
    endfunction

    // one row dotted with the force, scaled from q2.30 and clamped to 32 bits
    function automatic logic [31:0] row_dot(logic signed [67:0] m0, logic signed [67:0] m1,
                                            logic signed [67:0] m2, inout bit sat);
        logic signed [67:0] acc;
        logic [67:0] mag;
        logic [67:0] q;
        acc = m0 * force_q[0] + m1 * force_q[1] + m2 * force_q[2];
        mag = acc < 0 ? -acc : acc;
        q = (mag + (68'd1 << 29)) >> 30;
        if (acc < 0) begin
            if (q > 68'h8000_0000) begin
                q = 68'h8000_0000;
                sat = 1'b1;
            end
            return 32'(-q);
        end
        if (q > 68'h7FFF_FFFF) begin
            q = 68'h7FFF_FFFF;
            sat = 1'b1;
        end
        return 32'(q);
    endfunction

    function automatic t_force_out local_force_of(t_beam_in b);
        longint             dif [3];
        logic [63:0]        a [3];
        logic [63:0]        cm [3];
        logic [63:0]        mx;
        logic [63:0]        len;
        logic [63:0]        den;
        logic signed [67:0] m [9];
        logic signed [67:0] one;
        bit                 nx, ny, nz;
        bit                 sat;
        t_force_out         r;
        dif[0] = longint'(b.end_x) - longint'(b.start_x);
        dif[1] = longint'(b.end_y) - longint'(b.start_y);
        dif[2] = longint'(b.end_z) - longint'(b.start_z);
        for (int i = 0; i < 3; i++) begin
            a[i] = dif[i] < 0 ? -dif[i] : dif[i];
            cm[i] = 0;
        end
        mx = a[0];
        if (a[1] > mx) mx = a[1];
        if (a[2] > mx) mx = a[2];
        if (mx != 0) begin
            // bring the largest magnitude into [2^30, 2^31)
            if (mx >= (64'd1 << 31)) begin
                for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
            end else begin
                while (mx < (64'd1 << 30)) begin
                    mx = mx << 1;
                    for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
                end
            end
            len = isqrt_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
            for (int i = 0; i < 3; i++) begin
                cm[i] = div_nearest(a[i] << 30, len);
                if (cm[i] > (64'd1 << 30)) cm[i] = 64'd1 << 30;
            end
        end
        nx = dif[0] < 0;
        ny = dif[1] < 0;
        nz = dif[2] < 0;
        one = 68'sd1 <<< 30;
        if (cm[1] == (64'd1 << 30)) begin
            // vertical beam: fixed permutation rows
            m[1] = ny ? -one : one;
            m[0] = 0; m[2] = 0;
            m[3] = -m[1]; m[4] = 0; m[5] = 0;
            m[6] = 0; m[7] = 0; m[8] = one;
        end else begin
            den = isqrt_floor((64'd1 << 60) - cm[1] * cm[1]);
            m[0] = nx ? -$signed({4'b0, cm[0]}) : $signed({4'b0, cm[0]});
            m[1] = ny ? -$signed({4'b0, cm[1]}) : $signed({4'b0, cm[1]});
            m[2] = nz ? -$signed({4'b0, cm[2]}) : $signed({4'b0, cm[2]});
            m[3] = entry_of(cm[0] * cm[1], den, (nx == ny) && (cm[0] * cm[1] != 0));
            m[4] = $signed({4'b0, den});
            m[5] = entry_of(cm[1] * cm[2], den, (ny == nz) && (cm[1] * cm[2] != 0));
            m[6] = entry_of(cm[2] << 30, den, !nz && cm[2] != 0);
            m[7] = 0;
            m[8] = entry_of(cm[0] << 30, den, nx);
        end
        sat = 1'b0;
        r.local_axial   = row_dot(m[0], m[1], m[2], sat);
        r.local_normal  = row_dot(m[3], m[4], m[5], sat);
        r.local_lateral = row_dot(m[6], m[7], m[8], sat);
        r.saturated     = sat;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    int burst_left = 0;

    // offer one beat, wait for it to be taken, then maybe open a gap
    task automatic send_beam(t_beam_in b, bit typed, t_force_out typed_force);
        int gap;
        @(negedge i_clk);
        i_beam <= b;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_forces.push_back(typed ? typed_force : local_force_of(b));
        beams_sent++;
        if (b.start_x == b.end_x && b.start_z == b.end_z && b.start_y != b.end_y)
            vertical_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // end of burst: idle for a while, then start a new burst
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 120)
                                                  : $urandom_range(1, 20);
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_forces.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // write one register; only called with the block idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FORCE_X) force_q[0] = $signed(val);
        else if (idx == CFG_FORCE_Y) force_q[1] = $signed(val);
        else if (idx == CFG_FORCE_Z) force_q[2] = $signed(val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_force(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz);
        wait_idle();
        write_reg(CFG_FORCE_X, fx);
        write_reg(CFG_FORCE_Y, fy);
        write_reg(CFG_FORCE_Z, fz);
        // dropped write must leave the force alone
        write_reg(CFG_NONE, $urandom);
    endtask

    function automatic logic [31:0] small_val();
        return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
    endfunction

    // random beam, shaped toward the interesting directions
    function automatic t_beam_in random_beam();
        t_beam_in b;
        int kind;
        kind = $urandom_range(0, 9);
        b.start_x = $urandom; b.start_y = $urandom; b.start_z = $urandom;
        case (kind)
            0, 1, 2: begin
                b.end_x = $urandom; b.end_y = $urandom; b.end_z = $urandom;
            end
            3, 4: begin
                b.end_x = b.start_x + small_val();
                b.end_y = b.start_y + small_val();
                b.end_z = b.start_z + small_val();
            end
            5: begin
                // vertical beam
                b.end_x = b.start_x; b.end_z = b.start_z;
                b.end_y = b.start_y + ($urandom_range(0, 1) ? $urandom | 1 : 32'd1);
            end
            6: begin
                // nearly vertical: tiny side offsets against a long rise
                b.end_x = b.start_x + $urandom_range(0, 4) - 2;
                b.end_z = b.start_z + $urandom_range(0, 4) - 2;
                b.end_y = b.start_y + ($urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000);
            end
            7: begin
                b.end_x = b.start_x; b.end_y = b.start_y; b.end_z = b.start_z;
            end
            8: begin
                // horizontal or axis aligned beam
                b.end_x = $urandom_range(0, 1) ? b.start_x : $urandom;
                b.end_y = b.start_y;
                b.end_z = $urandom_range(0, 1) ? b.start_z : $urandom;
            end
            default: begin
                b.start_x = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                b.end_x = ~b.start_x;
                b.end_y = $urandom; b.end_z = $urandom;
            end
        endcase
        return b;
    endfunction

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------
    typedef struct {
        t_beam_in   beam;
        bit         typed;
        t_force_out result;
    } t_beam_row;

    localparam logic [31:0] Q1   = 32'h0001_0000;
    localparam logic [31:0] QMIN = 32'h8000_0000;
    localparam logic [31:0] QMAX = 32'h7FFF_FFFF;

    // force (1,0,0) after reset makes the first rows easy to read off
    t_beam_row reset_rows [] = '{
        // zero-length beam at the origin: everything zero
        '{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0}},
        // zero-length beam at the extremes
        '{'{QMIN, QMAX, QMIN, QMIN, QMAX, QMIN}, 1, '{0, 0, 0, 0}},
        // unit beam along +x: the whole force is axial
        '{'{0, 0, 0, Q1, 0, 0}, 1, '{Q1, 0, 0, 0}},
        // along -x
        '{'{Q1, 0, 0, 0, 0, 0}, 1, '{-Q1, 0, 0, 0}},
        // vertical up: normal is -1.0
        '{'{0, 0, 0, 0, Q1, 0}, 1, '{0, -Q1, 0, 0}},
        // vertical down over the full range
        '{'{0, QMAX, 0, 0, QMIN, 0}, 1, '{0, Q1, 0, 0}},
        '{'{0, 0, 0, 0, 0, Q1}, 0, '{0, 0, 0, 0}},
        '{'{0, 0, 0, Q1, Q1, Q1}, 0, '{0, 0, 0, 0}},
        '{'{QMIN, QMIN, QMIN, QMAX, QMAX, QMAX}, 0, '{0, 0, 0, 0}},
        '{'{QMAX, QMAX, QMAX, QMIN, QMIN, QMIN}, 0, '{0, 0, 0, 0}},
        '{'{QMAX, 0, QMIN, QMIN, 0, QMAX}, 0, '{0, 0, 0, 0}},
        '{'{0, 0, 0, 1, 32'h4000_0000, 0}, 0, '{0, 0, 0, 0}},
        '{'{0, 0, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF}, 0, '{0, 0, 0, 0}}
    };

    // rows for the large forces: saturation shows up here
    t_beam_row heavy_rows [] = '{
        '{'{0, 0, 0, Q1, Q1, Q1}, 0, '{0, 0, 0, 0}},
        '{'{0, 0, 0, -Q1, -Q1, -Q1}, 0, '{0, 0, 0, 0}},
        '{'{0, 0, 0, Q1, 0, Q1}, 0, '{0, 0, 0, 0}},
        '{'{0, 0, 0, 0, Q1, 0}, 0, '{0, 0, 0, 0}},
        '{'{0, 0, 0, 0, -Q1, 0}, 0, '{0, 0, 0, 0}},
        '{'{QMIN, 0, QMAX, QMAX, QMAX, QMIN}, 0, '{0, 0, 0, 0}},
        '{'{5, 5, 5, 5, 5, 5}, 0, '{0, 0, 0, 0}},
        '{'{0, 0, 0, 3, 32'h7FFF_0000, 2}, 0, '{0, 0, 0, 0}}
    };

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        force_q[0] = $signed(FORCE_X_RESET);
        force_q[1] = 0;
        force_q[2] = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (reset_rows[k]) send_beam(reset_rows[k].beam, reset_rows[k].typed,
                                          reset_rows[k].result);

        set_force(QMAX, QMAX, QMAX);
        foreach (heavy_rows[k]) send_beam(heavy_rows[k].beam, 0, '0);
        for (int n = 0; n < RANDOM_BEAMS / 4; n++) send_beam(random_beam(), 0, '0);

        set_force(QMIN, QMIN, QMIN);
        foreach (heavy_rows[k]) send_beam(heavy_rows[k].beam, 0, '0);
        for (int n = 0; n < RANDOM_BEAMS / 4; n++) send_beam(random_beam(), 0, '0);

        set_force(0, 0, 0);
        for (int n = 0; n < 20; n++) send_beam(random_beam(), 0, '0);

        // a few random force settings for the remainder
        for (int p = 0; p < 4; p++) begin
            set_force($urandom_range(0, 1) ? $urandom : small_val(),
                      $urandom_range(0, 1) ? $urandom : small_val(),
                      $urandom_range(0, 1) ? $urandom : small_val());
            for (int n = 0; n < RANDOM_BEAMS / 8; n++) send_beam(random_beam(), 0, '0);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_forces.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        stimulus_done = 1'b1;

        $display("tb: %0d beams (%0d vertical), %0d results, %0d saturated, 8 force settings",
                 beams_sent, vertical_sent, forces_seen, sat_seen);
        $display("tb: %0d mismatches, %0d results still outstanding",
                 mismatches, expected_forces.size());
        if (mismatches == 0 && expected_forces.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // receiver stall pattern, with one long hold to fill the pipe
    // ---------------------------------------------------------------
    initial begin
        int mode;
        int span;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && beams_sent > 200) begin
                // hold off well past the pipe depth so the input backs up
                long_hold_done = 1'b1;
                i_stall <= 1'b1;
                span = 3 * PIPE_DEPTH;
                repeat (span) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(1, 60);
                repeat (span) begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 9) < 3);
                        default: i_stall <= ($urandom_range(0, 9) < 8);
                    endcase
                    @(negedge i_clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_force_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            forces_seen++;
            if (o_force.saturated) sat_seen++;
            if (expected_forces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: result beat with nothing expected: %h", o_force);
            end else begin
                want = expected_forces.pop_front();
                if (o_force.local_axial !== want.local_axial ||
                    o_force.local_normal !== want.local_normal ||
                    o_force.local_lateral !== want.local_lateral ||
                    o_force.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: result %0d: exp %h %h %h %b, got %h %h %h %b",
                                 forces_seen, want.local_axial, want.local_normal,
                                 want.local_lateral, want.saturated, o_force.local_axial,
                                 o_force.local_normal, o_force.local_lateral,
                                 o_force.saturated);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT && !stimulus_done) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
